>>> hw/rtl/gboe_pkg.sv
// ============================================================================
// Breadth-first search engine package
// Shared types and codes for the controller and the datapath.
// ============================================================================
package gboe_pkg;

   // Width of a node field on the ports
   localparam int NODE_W = 6;

   // Input command codes
   localparam logic CMD_EDGE   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_DROPPED = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_TAIL_RD,
      S_APPEND,
      S_LINK,
      S_RESULT,
      S_QUEUE_RD,
      S_HEAD_RD,
      S_LINK_LD,
      S_ENTRY_RD,
      S_CHECK,
      S_FINAL
   } ctrl_state_type;

   // Kind of single result that ends an edge or a failed search
   typedef enum logic [1:0] {
      KIND_ACK,
      KIND_DROP,
      KIND_ERR
   } result_kind_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic sel_second;
      logic tail_rd;
      logic append_wr;
      logic link_wr;
      logic bump_used;
      logic search_init;
      logic queue_rd;
      logic head_rd;
      logic link_ld;
      logic entry_rd;
      logic discover;
      logic link_next;
      logic emit_ack;
      logic emit_drop;
      logic emit_err;
      logic emit_final;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_search;
      logic edge_bad;
      logic start_bad;
      logic tail_valid;
      logic queue_more;
      logic link_end;
      logic nb_fresh;
      logic out_free;
   } dp_status_type;

endpackage

>>> hw/rtl/graph_bfs_order_engine_top.sv
// An accepted edge gives its result after two list appends, each a tail read,
// an entry write and, for a non-empty list, a link write.
// A search reads each visited node from the queue and walks its neighbor entries in turn,
// through the single read port of the entry store; one item is worked at a time.
// Reset clears control state and the per-node list valid bits; no
// clearing pass runs, and the block takes a transaction right after reset.
// ============================================================================
// Breadth-first search engine top level
// Loads undirected edges into adjacency lists and emits breadth-first order.
// ============================================================================
module graph_bfs_order_engine_top
   import gboe_pkg::*;
#(
   parameter int MAX_NODES   = 64,
   parameter int MAX_ENTRIES = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // first_node [5:0], second_node [11:6], zero pad
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // node [5:0], zero pad
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser   // status
);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [NODE_W-1:0] rsp_node;

   // Controller
   gboe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   gboe_dp #(
      .MAX_NODES   (MAX_NODES),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_tuser),
      .req_first   (req_tdata[5:0]),
      .req_second  (req_tdata[11:6]),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_node    (rsp_node),
      .rsp_last    (rsp_tlast),
      .rsp_status  (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, rsp_node};

`ifndef SYNTHESIS
   // A found node only leaves the walk when the result register can take the held one.
   assert property (@(posedge clock) disable iff (reset) cmd.discover |-> status.out_free)
      else $error("node discovered while result register was blocked");

   // The closing result of a search is loaded only into a free result register.
   assert property (@(posedge clock) disable iff (reset) cmd.emit_final |-> status.out_free)
      else $error("final search result loaded over a waiting result");

   // After a transaction is taken the block stays busy for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted twice in a row");
`endif

endmodule

>>> hw/rtl/gboe_ctrl.sv
// ============================================================================
// Breadth-first search engine controller
// Sequences edge appends and the queue-driven search walk.
// ============================================================================
module gboe_ctrl
   import gboe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type  state_ff, state_in;
   logic            sel_ff, sel_in;
   result_kind_type kind_ff, kind_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= 1'b0;
         kind_ff  <= KIND_ACK;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         kind_ff  <= kind_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      sel_in         = sel_ff;
      kind_in        = kind_ff;
      cmd            = '0;
      cmd.sel_second = sel_ff;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!status.is_search) begin
               if (status.edge_bad) begin
                  kind_in  = KIND_DROP;
                  state_in = S_RESULT;
               end else begin
                  sel_in   = 1'b0;
                  state_in = S_TAIL_RD;
               end
            end else if (status.start_bad) begin
               kind_in  = KIND_ERR;
               state_in = S_RESULT;
            end else begin
               cmd.search_init = 1'b1;
               state_in        = S_QUEUE_RD;
            end
         end
         S_TAIL_RD: begin
            cmd.tail_rd = 1'b1;
            state_in    = S_APPEND;
         end
         S_APPEND: begin
            cmd.append_wr = 1'b1;
            if (status.tail_valid) begin
               state_in = S_LINK;
            end else begin
               cmd.bump_used = 1'b1;
               sel_in        = 1'b1;
               kind_in       = KIND_ACK;
               state_in      = sel_ff ? S_RESULT : S_TAIL_RD;
            end
         end
         S_LINK: begin
            cmd.link_wr   = 1'b1;
            cmd.bump_used = 1'b1;
            sel_in        = 1'b1;
            kind_in       = KIND_ACK;
            state_in      = sel_ff ? S_RESULT : S_TAIL_RD;
         end
         S_RESULT: begin
            if (status.out_free) begin
               cmd.emit_ack  = (kind_ff == KIND_ACK);
               cmd.emit_drop = (kind_ff == KIND_DROP);
               cmd.emit_err  = (kind_ff == KIND_ERR);
               state_in      = S_IDLE;
            end
         end
         S_QUEUE_RD: begin
            if (status.queue_more) begin
               cmd.queue_rd = 1'b1;
               state_in     = S_HEAD_RD;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_HEAD_RD: begin
            cmd.head_rd = 1'b1;
            state_in    = S_LINK_LD;
         end
         S_LINK_LD: begin
            cmd.link_ld = 1'b1;
            state_in    = S_ENTRY_RD;
         end
         S_ENTRY_RD: begin
            if (status.link_end) begin
               state_in = S_QUEUE_RD;
            end else begin
               cmd.entry_rd = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            // A new node pushes the held one out, so it waits for the output slot.
            if (!status.nb_fresh) begin
               cmd.link_next = 1'b1;
               state_in      = S_ENTRY_RD;
            end else if (status.out_free) begin
               cmd.discover  = 1'b1;
               cmd.link_next = 1'b1;
               state_in      = S_ENTRY_RD;
            end
         end
         S_FINAL: begin
            if (status.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/gboe_dp.sv
// ============================================================================
// Breadth-first search engine datapath
// Adjacency stores, visited marks, work queue and the result register.
// ============================================================================
module gboe_dp
   import gboe_pkg::*;
#(
   parameter int MAX_NODES   = 64,
   parameter int MAX_ENTRIES = 256
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_command,
   input  logic [NODE_W-1:0] req_first,
   input  logic [NODE_W-1:0] req_second,
   input  dp_cmd_type        cmd,
   output dp_status_type     status,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [NODE_W-1:0] rsp_node,
   output logic              rsp_last,
   output logic [1:0]        rsp_status
);

   localparam int NI_W   = $clog2(MAX_NODES);
   localparam int QP_W   = NI_W + 1;
   localparam int ENT_W  = $clog2(MAX_ENTRIES);
   localparam int LINK_W = ENT_W + 1;
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_ENTRIES);

   // Memories
   logic [ENT_W-1:0]  head_mem  [MAX_NODES];
   logic [ENT_W-1:0]  tail_mem  [MAX_NODES];
   logic [NI_W-1:0]   nb_mem    [MAX_ENTRIES];
   logic [LINK_W-1:0] next_mem  [MAX_ENTRIES];
   logic [NI_W-1:0]   queue_mem [MAX_NODES];

   // Registers
   logic                 cmd_ff;
   logic [NODE_W-1:0]    a_ff, b_ff;
   logic [LINK_W-1:0]    used_ff;
   logic [MAX_NODES-1:0] valid_ff;
   logic [MAX_NODES-1:0] visited_ff;
   logic [QP_W-1:0]      rd_ff, wr_ff;
   logic [NI_W-1:0]      cur_ff;
   logic [ENT_W-1:0]     head_rd_ff, tail_rd_ff;
   logic                 tail_valid_ff;
   logic [NI_W-1:0]      nb_rd_ff;
   logic [LINK_W-1:0]    next_rd_ff;
   logic [LINK_W-1:0]    link_ff;
   logic [NI_W-1:0]      pend_ff;
   logic                 out_valid_ff;
   logic [NODE_W-1:0]    out_node_ff;
   logic                 out_last_ff;
   logic [1:0]           out_status_ff;

   logic [NODE_W-1:0] owner_node, nbr_node;
   logic [NI_W-1:0]   owner_idx, nbr_idx, start_idx;
   logic [ENT_W-1:0]  e_idx;
   logic              a_in_range, b_in_range, out_free, out_load;

   // Endpoint selection for the current append
   assign owner_node = cmd.sel_second ? b_ff : a_ff;
   assign nbr_node   = cmd.sel_second ? a_ff : b_ff;
   assign owner_idx  = NI_W'(owner_node);
   assign nbr_idx    = NI_W'(nbr_node);
   assign start_idx  = NI_W'(a_ff);
   assign e_idx      = used_ff[ENT_W-1:0];

   assign a_in_range = (32'(a_ff) < MAX_NODES);
   assign b_in_range = (32'(b_ff) < MAX_NODES);
   assign out_free   = !out_valid_ff || rsp_ready;
   assign out_load   = cmd.emit_ack || cmd.emit_drop || cmd.emit_err ||
                       cmd.emit_final || cmd.discover;

   // Status toward the controller
   always_comb begin
      status            = '0;
      status.is_search  = (cmd_ff == CMD_SEARCH);
      status.edge_bad   = !a_in_range || !b_in_range ||
                          ((32'(used_ff) + 32'd2) > MAX_ENTRIES);
      status.start_bad  = !a_in_range || !valid_ff[start_idx];
      status.tail_valid = tail_valid_ff;
      status.queue_more = (rd_ff < wr_ff);
      status.link_end   = (32'(link_ff) >= MAX_ENTRIES);
      status.nb_fresh   = !visited_ff[nb_rd_ff] && (32'(wr_ff) < MAX_NODES);
      status.out_free   = out_free;
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff <= req_command;
         a_ff   <= req_first;
         b_ff   <= req_second;
      end
   end

   // List heads and tails, one write and one read port each
   always_ff @(posedge clock) begin
      if (cmd.append_wr) begin
         tail_mem[owner_idx] <= e_idx;
         if (!valid_ff[owner_idx]) begin
            head_mem[owner_idx] <= e_idx;
         end
      end
      if (cmd.tail_rd) begin
         tail_rd_ff <= tail_mem[owner_idx];
      end
      if (cmd.head_rd) begin
         head_rd_ff <= head_mem[cur_ff];
      end
   end

   // Entry store: neighbor and link of each entry
   always_ff @(posedge clock) begin
      if (cmd.append_wr) begin
         nb_mem[e_idx]   <= nbr_idx;
         next_mem[e_idx] <= LINK_NONE;
      end else if (cmd.link_wr) begin
         next_mem[tail_rd_ff] <= used_ff;
      end
      if (cmd.entry_rd) begin
         nb_rd_ff   <= nb_mem[link_ff[ENT_W-1:0]];
         next_rd_ff <= next_mem[link_ff[ENT_W-1:0]];
      end
   end

   // Work queue
   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         queue_mem[0] <= start_idx;
      end else if (cmd.discover) begin
         queue_mem[wr_ff[NI_W-1:0]] <= nb_rd_ff;
      end
      if (cmd.queue_rd) begin
         cur_ff <= queue_mem[rd_ff[NI_W-1:0]];
      end
   end

   // Allocation count and per-node list valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         valid_ff <= '0;
      end else begin
         if (cmd.bump_used) begin
            used_ff <= used_ff + LINK_W'(1);
         end
         if (cmd.append_wr) begin
            valid_ff[owner_idx] <= 1'b1;
         end
      end
   end

   // Search walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
      end else if (cmd.search_init) begin
         rd_ff <= '0;
         wr_ff <= QP_W'(1);
      end else begin
         if (cmd.queue_rd) begin
            rd_ff <= rd_ff + QP_W'(1);
         end
         if (cmd.discover) begin
            wr_ff <= wr_ff + QP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tail_rd) begin
         tail_valid_ff <= valid_ff[owner_idx];
      end
      if (cmd.search_init) begin
         // Only the start node is marked when a search begins.
         visited_ff <= MAX_NODES'(1) << start_idx;
         pend_ff    <= start_idx;
      end else if (cmd.discover) begin
         visited_ff[nb_rd_ff] <= 1'b1;
         pend_ff              <= nb_rd_ff;
      end
      if (cmd.link_ld) begin
         link_ff <= valid_ff[cur_ff] ? {1'b0, head_rd_ff} : LINK_NONE;
      end else if (cmd.link_next) begin
         link_ff <= next_rd_ff;
      end
   end

   // Result register: the held node leaves when the next one is found or at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_node_ff   <= (cmd.discover || cmd.emit_final) ? NODE_W'(pend_ff) : '0;
         out_last_ff   <= !cmd.discover;
         out_status_ff <= cmd.emit_drop ? STATUS_DROPPED :
                          cmd.emit_err  ? STATUS_UNKNOWN : STATUS_OK;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_node   = out_node_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_status = out_status_ff;

endmodule
